### hw/rtl/fsbs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fsbs_pkg: shared types and constants for the file signature byte scanner
// Field widths, magic pattern bytes and the signature kind encoding.
// ---------------------------------------------------------------------------
package fsbs_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned OFF_W           = 48;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned WIN_LEN         = 7;
  localparam int unsigned CMP_LEN         = WIN_LEN + 1;
  localparam int unsigned IN_DATA_W       = 56;
  localparam int unsigned OUT_DATA_W      = 48;
  localparam int unsigned OFFSET_BITS_DEF = 48;

  typedef enum logic [KIND_W-1:0] {
    SIG_JPEG = 3'd0,
    SIG_PDF  = 3'd1,
    SIG_ELF  = 3'd2,
    SIG_MFT  = 3'd3,
    SIG_GPT  = 3'd4
  } sig_kind_t;

  typedef struct packed {
    logic      hit;
    sig_kind_t kind;
  } match_t;

  // Pattern bytes.
  localparam logic [BYTE_W-1:0] B_FF = 8'hFF;
  localparam logic [BYTE_W-1:0] B_D8 = 8'hD8;
  localparam logic [BYTE_W-1:0] B_25 = 8'h25;  // '%'
  localparam logic [BYTE_W-1:0] B_50 = 8'h50;  // 'P'
  localparam logic [BYTE_W-1:0] B_44 = 8'h44;  // 'D'
  localparam logic [BYTE_W-1:0] B_46 = 8'h46;  // 'F'
  localparam logic [BYTE_W-1:0] B_7F = 8'h7F;
  localparam logic [BYTE_W-1:0] B_45 = 8'h45;  // 'E'
  localparam logic [BYTE_W-1:0] B_4C = 8'h4C;  // 'L'
  localparam logic [BYTE_W-1:0] B_49 = 8'h49;  // 'I'
  localparam logic [BYTE_W-1:0] B_30 = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] B_20 = 8'h20;  // ' '
  localparam logic [BYTE_W-1:0] B_41 = 8'h41;  // 'A'
  localparam logic [BYTE_W-1:0] B_52 = 8'h52;  // 'R'
  localparam logic [BYTE_W-1:0] B_54 = 8'h54;  // 'T'

endpackage : fsbs_pkg
`default_nettype wire

### hw/rtl/fsbs_match.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fsbs_match: magic pattern classifier
// Compares eight consecutive bytes against the five signatures in priority
// order and returns at most one hit with its kind.
// ---------------------------------------------------------------------------
module fsbs_match (
  input  logic [fsbs_pkg::CMP_LEN*fsbs_pkg::BYTE_W-1:0] win,  // byte 0 in the lowest bits
  output fsbs_pkg::match_t                              res
);
  import fsbs_pkg::*;

  logic [BYTE_W-1:0] b [CMP_LEN];

  always_comb begin
    for (int i = 0; i < CMP_LEN; i++) begin
      b[i] = win[i*BYTE_W +: BYTE_W];
    end
  end

  always_comb begin
    res.hit  = 1'b1;
    res.kind = SIG_JPEG;
    priority if (b[0] == B_FF && b[1] == B_D8 && b[2] == B_FF) begin
      res.kind = SIG_JPEG;
    end else if (b[0] == B_25 && b[1] == B_50 && b[2] == B_44 && b[3] == B_46) begin
      res.kind = SIG_PDF;
    end else if (b[0] == B_7F && b[1] == B_45 && b[2] == B_4C && b[3] == B_46) begin
      res.kind = SIG_ELF;
    end else if (b[0] == B_46 && b[1] == B_49 && b[2] == B_4C && b[3] == B_45 &&
                 b[4] == B_30) begin
      res.kind = SIG_MFT;
    end else if (b[0] == B_45 && b[1] == B_46 && b[2] == B_49 && b[3] == B_20 &&
                 b[4] == B_50 && b[5] == B_41 && b[6] == B_52 && b[7] == B_54) begin
      res.kind = SIG_GPT;
    end else begin
      res.hit = 1'b0;
    end
  end

endmodule : fsbs_match
`default_nettype wire

### hw/rtl/file_signature_byte_scanner_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// file_signature_byte_scanner_top: streaming magic number scanner
// Finds JPEG, PDF, ELF, NTFS MFT record and GPT header signatures in a
// byte stream and reports the kind and absolute offset of each match.
// ---------------------------------------------------------------------------
// The block takes one byte per cycle unless a stalled output holds it. Start
// position s of a buffer is tested when byte s+7 arrives, so it is reported
// only if that byte is not flagged last; the last eight start positions of a
// buffer are never reported. Positions are counted from the byte flagged in
// in_tuser, whose transaction also carries the buffer base offset; bytes
// before any such mark count from zero with base zero. The reported offset is
// base plus start position, wrapped to OFFSET_BITS bits (at most OFF_W). An
// input register captures the eight-byte window and start position, and the
// classifier and offset adder feed the output register; each accepted byte
// passes through these two stages in order.
// ---------------------------------------------------------------------------
module file_signature_byte_scanner_top #(
  parameter int unsigned OFFSET_BITS = fsbs_pkg::OFFSET_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fsbs_pkg::IN_DATA_W-1:0]      in_tdata,   // data_byte, base_offset
  input  logic                                in_tuser,   // first_of_buffer
  input  logic                                in_tlast,   // last_of_buffer
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fsbs_pkg::OUT_DATA_W-1:0]     out_tdata,  // match_offset
  output logic [fsbs_pkg::KIND_W-1:0]         out_tuser   // signature_kind
);
  import fsbs_pkg::*;

  localparam int unsigned MaskBits = (OFFSET_BITS < OFF_W) ? OFFSET_BITS : OFF_W;
  localparam logic [63:0] MaskWide = (64'd1 << MaskBits) - 64'd1;
  localparam logic [OFF_W-1:0] OffMask = MaskWide[OFF_W-1:0];
  localparam logic [OFF_W-1:0] PosMax = {OFF_W{1'b1}};
  localparam logic [OFF_W-1:0] WinLenOff = OFF_W'(WIN_LEN);

  // Scanner state.
  logic [BYTE_W-1:0] window_r [WIN_LEN];
  logic [OFF_W-1:0]  pos_r, pos_nxt;
  logic [OFF_W-1:0]  base_r, base_nxt;

  // Input stage.
  logic                          s1_v_r, s1_v_nxt;
  logic                          s1_elig_r;
  logic [CMP_LEN*BYTE_W-1:0]     s1_win_r;
  logic [OFF_W-1:0]              s1_start_r;
  logic [OFF_W-1:0]              s1_base_r;

  // Output stage.
  logic                          out_v_r, out_v_nxt;
  logic [OFF_W-1:0]              out_off_r;
  sig_kind_t                     out_kind_r;

  logic              in_acc, out_free, s1_fire;
  logic [BYTE_W-1:0] data_byte;
  logic [OFF_W-1:0]  pos_cur;
  logic              elig;
  logic [CMP_LEN*BYTE_W-1:0] win_cur;
  logic [OFF_W-1:0]  sum;
  match_t            mres;

  assign out_free  = !out_v_r || out_tready;
  assign s1_fire   = s1_v_r && out_free;
  assign in_tready = !s1_v_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign data_byte = in_tdata[BYTE_W-1:0];
  assign pos_cur   = in_tuser ? '0 : pos_r;
  assign base_nxt  = in_tuser ? in_tdata[BYTE_W +: OFF_W] : base_r;
  assign pos_nxt   = (pos_cur != PosMax) ? pos_cur + 1'b1 : PosMax;
  assign elig      = (pos_cur >= WinLenOff) && !in_tlast;

  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      win_cur[i*BYTE_W +: BYTE_W] = window_r[i];
    end
    win_cur[WIN_LEN*BYTE_W +: BYTE_W] = data_byte;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_v_nxt = 1'b0;
    end
  end

  fsbs_match u_match (
    .win (s1_win_r),
    .res (mres)
  );

  assign sum = s1_base_r + s1_start_r;

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_free) begin
      out_v_nxt = s1_v_r && s1_elig_r && mres.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      base_r  <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (in_acc) begin
        pos_r  <= pos_nxt;
        base_r <= base_nxt;
      end
    end
  end

  // Payload registers need no reset; the window is only examined once seven
  // bytes of the current buffer have been shifted in.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        window_r[i] <= window_r[i+1];
      end
      window_r[WIN_LEN-1] <= data_byte;
      s1_win_r   <= win_cur;
      s1_elig_r  <= elig;
      s1_start_r <= pos_cur - WinLenOff;
      s1_base_r  <= base_nxt;
    end
    if (s1_fire) begin
      out_off_r  <= sum & OffMask;
      out_kind_r <= mres.kind;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_off_r;
  assign out_tuser  = out_kind_r;

endmodule : file_signature_byte_scanner_top
`default_nettype wire
